// ----- rtl/lfpe_pkg.sv -----
// Shared types and constants for the LED frame PWM encoder.
// Depends on nothing; every other file of the block imports it.
package lfpe_pkg;

  localparam int unsigned WORD_W = 24;
  localparam int unsigned BIT_IDX_W = $clog2(WORD_W);
  localparam logic [BIT_IDX_W-1:0] BIT_IDX_MSB = BIT_IDX_W'(WORD_W - 1);

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_EOF   = 1'b1;

  localparam logic [7:0] CFG_DUTY_ZERO = 8'd0;
  localparam logic [7:0] CFG_DUTY_ONE  = 8'd1;
  localparam logic [7:0] CFG_RESET_GAP = 8'd2;
  localparam logic [7:0] CFG_LEADING   = 8'd3;

  localparam logic [7:0] RST_DUTY_ZERO = 8'd3;
  localparam logic [7:0] RST_DUTY_ONE  = 8'd6;
  localparam logic [7:0] RST_RESET_GAP = 8'd80;
  localparam logic [3:0] RST_LEADING   = 4'd1;

  localparam logic [7:0] DUTY_IDLE = 8'd0;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] slot_count;
    logic       frame_done;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] duty_zero_bit;
    logic [7:0] duty_one_bit;
    logic [7:0] reset_gap_slots;
    logic [3:0] leading_slots;
  } cfg_t;

  // One classified command between front and back end.
  typedef struct packed {
    logic              is_eof;
    logic              lead;
    logic [3:0]        lead_cnt;
    logic [7:0]        gap;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage

// ----- rtl/led_frame_pwm_encoder_top.sv -----
// An item's first result passes through a queue entry, then the back end's output register.
// Throughput: one result per cycle while out_ready is high; a pixel makes 24 results, or 25 with a
// leading run, and an end of frame makes one, the back end emitting one slot run per cycle.
// The front end takes a new item every cycle while the command queue has room.
// Reset (rst_n low, synchronous): registers to defaults, frame closed, queue and output empty.
// Depends on lfpe_pkg, lfpe_front, lfpe_queue and lfpe_back.
module led_frame_pwm_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  // pixel / end-of-frame input
  input  logic                in_valid,
  output logic                in_ready,
  input  lfpe_pkg::in_item_t  in_item,
  // slot run output
  output logic                out_valid,
  input  logic                out_ready,
  output lfpe_pkg::out_item_t out_item
);
  import lfpe_pkg::*;

  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             q_push;
  cmd_t             push_cmd;
  logic             q_pop;
  logic             head_valid;
  cmd_t             head_cmd;
  logic             q_full;
  logic [LVL_W-1:0] q_level;
  logic             in_frame;

  // Config writes always complete; unlisted indexes drop the data.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DUTY_ZERO: cfg_nxt.duty_zero_bit   = cfg_data;
        CFG_DUTY_ONE:  cfg_nxt.duty_one_bit    = cfg_data;
        CFG_RESET_GAP: cfg_nxt.reset_gap_slots = cfg_data;
        CFG_LEADING:   cfg_nxt.leading_slots   = cfg_data[3:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_zero_bit   <= RST_DUTY_ZERO;
      cfg_r.duty_one_bit    <= RST_DUTY_ONE;
      cfg_r.reset_gap_slots <= RST_RESET_GAP;
      cfg_r.leading_slots   <= RST_LEADING;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify the item, scale colours, decide on the leading run.
  lfpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .in_frame (in_frame)
  );

  // Queue: decouple item transfers from slot emission.
  lfpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (q_full),
    .level      (q_level)
  );

  // Back: walk the head command, hold each result in the output register.
  lfpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (head_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_pixel_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.func == FUNC_PIXEL) |=> in_frame)
    else $error("pixel transfer did not open the frame");

  a_eof_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.func == FUNC_EOF) |=> !in_frame)
    else $error("end of frame did not close the frame");

  a_ready_tracks_level: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (q_level != LVL_W'(QUEUE_DEPTH)))
    else $error("input ready disagrees with queue level");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.slot_count != 8'd0))
    else $error("result with zero slot count");
`endif

endmodule

// ----- rtl/lfpe_front.sv -----
// Front end: accepts items, scales colours, tracks frame state, emits commands.
// Depends on lfpe_pkg.
module lfpe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  lfpe_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  lfpe_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output lfpe_pkg::cmd_t    q_cmd,
  output logic              in_frame
);
  import lfpe_pkg::*;

  logic       in_frame_r;
  logic       in_frame_nxt;
  logic [8:0] scale;
  logic [16:0] prod_g;
  logic [16:0] prod_r;
  logic [16:0] prod_b;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign in_frame = in_frame_r;

  assign scale  = {1'b0, in_item.brightness} + 9'd1;
  assign prod_g = {9'd0, in_item.green} * {8'd0, scale};
  assign prod_r = {9'd0, in_item.red} * {8'd0, scale};
  assign prod_b = {9'd0, in_item.blue} * {8'd0, scale};

  always_comb begin
    q_cmd.is_eof   = (in_item.func == FUNC_EOF);
    q_cmd.lead     = !in_frame_r && (cfg.leading_slots != 4'd0);
    q_cmd.lead_cnt = cfg.leading_slots;
    q_cmd.gap      = (cfg.reset_gap_slots == 8'd0) ? 8'd1 : cfg.reset_gap_slots;
    q_cmd.word     = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    if (q_push) begin
      in_frame_nxt = (in_item.func == FUNC_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

// ----- rtl/lfpe_queue.sv -----
// Short command queue between front and back end.
// Depends on lfpe_pkg for the command type.
module lfpe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  lfpe_pkg::cmd_t             push_cmd,
  input  logic                       pop,
  output logic                       head_valid,
  output lfpe_pkg::cmd_t             head_cmd,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import lfpe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign level      = count_r;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/lfpe_back.sv -----
// Back end: expands one command into slot runs, one result per cycle while the output is not stalled.
// Depends on lfpe_pkg.
module lfpe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lfpe_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  lfpe_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lfpe_pkg::out_item_t out_item
);
  import lfpe_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r;
  out_item_t            res;
  logic                 lead_done_r, lead_done_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic                 load;
  logic                 bit_val;

  assign load      = q_valid && (!out_valid_r || out_ready);
  assign bit_val   = q_cmd.word[bit_idx_r];
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    res           = '0;
    q_pop         = 1'b0;
    lead_done_nxt = lead_done_r;
    bit_idx_nxt   = bit_idx_r;
    priority if (q_cmd.is_eof) begin
      res.duty        = DUTY_IDLE;
      res.slot_count  = q_cmd.gap;
      res.frame_done  = 1'b1;
      res.last_of_run = 1'b1;
      q_pop           = load;
    end else if (q_cmd.lead && !lead_done_r) begin
      res.duty       = DUTY_IDLE;
      res.slot_count = {4'd0, q_cmd.lead_cnt};
      if (load) begin
        lead_done_nxt = 1'b1;
      end
    end else begin
      res.duty        = bit_val ? cfg.duty_one_bit : cfg.duty_zero_bit;
      res.slot_count  = 8'd1;
      res.last_of_run = (bit_idx_r == '0);
      if (load) begin
        if (bit_idx_r == '0) begin
          q_pop         = 1'b1;
          bit_idx_nxt   = BIT_IDX_MSB;
          lead_done_nxt = 1'b0;
        end else begin
          bit_idx_nxt = bit_idx_r - BIT_IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lead_done_r <= 1'b0;
      bit_idx_r   <= BIT_IDX_MSB;
    end else begin
      out_valid_r <= out_valid_nxt;
      lead_done_r <= lead_done_nxt;
      bit_idx_r   <= bit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

endmodule

// ----- tb/sv/lfpe_slot_checker.sv -----
`timescale 1ns / 100ps
// Slot-run checker for the LED frame PWM encoder: watches the config, input and
// output transfers, predicts every slot run and compares results in order.
// Depends on lfpe_pkg.
module lfpe_slot_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lfpe_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lfpe_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  runs_outstanding
);
  import lfpe_pkg::*;

  logic [7:0] zero_duty;
  logic [7:0] one_duty;
  logic [7:0] gap_slots;
  logic [3:0] lead_slots;
  logic       frame_open;

  out_item_t expected_runs[$];

  function automatic logic [7:0] scale_colour(logic [7:0] value, logic [7:0] bright);
    logic [16:0] prod;
    prod = {9'd0, value} * ({9'd0, bright} + 17'd1);
    return prod[15:8];
  endfunction

  always @(posedge clk) begin : watch
    out_item_t run;
    out_item_t want;
    logic [WORD_W-1:0] word;
    if (!rst_n) begin
      zero_duty  = RST_DUTY_ZERO;
      one_duty   = RST_DUTY_ONE;
      gap_slots  = RST_RESET_GAP;
      lead_slots = RST_LEADING;
      frame_open = 1'b0;
      expected_runs.delete();
    end else begin
      // Compare before pushing: a result never belongs to an item taken this edge.
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected slot run: duty %0d slot_count %0d", out_item.duty,
                 out_item.slot_count);
          fail_count++;
        end else begin
          want = expected_runs.pop_front();
          if (out_item.duty !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, out_item.duty);
            fail_count++;
          end
          if (out_item.slot_count !== want.slot_count) begin
            $error("slot_count: expected %0d, actual %0d", want.slot_count,
                   out_item.slot_count);
            fail_count++;
          end
          if (out_item.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, actual %0d", want.frame_done,
                   out_item.frame_done);
            fail_count++;
          end
          if (out_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   out_item.last_of_run);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DUTY_ZERO: zero_duty  = cfg_data;
          CFG_DUTY_ONE:  one_duty   = cfg_data;
          CFG_RESET_GAP: gap_slots  = cfg_data;
          CFG_LEADING:   lead_slots = cfg_data[3:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (in_item.func == FUNC_EOF) begin
          // A zero gap still goes out as a single slot.
          run.duty        = DUTY_IDLE;
          run.slot_count  = (gap_slots == 8'd0) ? 8'd1 : gap_slots;
          run.frame_done  = 1'b1;
          run.last_of_run = 1'b1;
          expected_runs.push_back(run);
          frame_open = 1'b0;
        end else begin
          if (!frame_open && lead_slots != 4'd0) begin
            run.duty        = DUTY_IDLE;
            run.slot_count  = {4'd0, lead_slots};
            run.frame_done  = 1'b0;
            run.last_of_run = 1'b0;
            expected_runs.push_back(run);
          end
          word = {scale_colour(in_item.green, in_item.brightness),
                  scale_colour(in_item.red, in_item.brightness),
                  scale_colour(in_item.blue, in_item.brightness)};
          for (int i = WORD_W - 1; i >= 0; i--) begin
            run.duty        = word[i] ? one_duty : zero_duty;
            run.slot_count  = 8'd1;
            run.frame_done  = 1'b0;
            run.last_of_run = (i == 0);
            expected_runs.push_back(run);
          end
          frame_open = 1'b1;
        end
      end
    end
    runs_outstanding = expected_runs.size();
  end

endmodule

// ----- tb/sv/led_frame_pwm_encoder_top_test.sv -----
`timescale 1ns / 100ps
// Top-level test of led_frame_pwm_encoder_top: drives pixels, end-of-frame items
// and register writes with random stalls; lfpe_slot_checker does the checking.
// Depends on lfpe_pkg, lfpe_slot_checker and the encoder RTL.
module led_frame_pwm_encoder_top_test;
  import lfpe_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int fail_count;
  int runs_outstanding;

  // When set, both sides run back to back with no idle cycles.
  bit no_stall;

  led_frame_pwm_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  lfpe_slot_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .fail_count       (fail_count),
    .runs_outstanding (runs_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: idle a random number of cycles before each transfer, then hold
  // ready high until the transfer happens.
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Offer one item: idle first, then hold valid and payload until the transfer.
  // Returns at the falling edge after the transfer with valid still high, so a
  // back-to-back item keeps valid up without a low blip.
  task automatic send_item(in_item_t item);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted run has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (runs_outstanding != 0) @(negedge clk);
  endtask

  // Register write; only called while the encoder is drained. Valid drops
  // after the transfer and stays low until the task returns.
  task automatic write_reg(logic [7:0] index, logic [7:0] data);
    cfg_index <= index;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] bright);
    in_item_t item;
    item.func       = FUNC_PIXEL;
    item.red        = r;
    item.green      = g;
    item.blue       = b;
    item.brightness = bright;
    return item;
  endfunction

  function automatic in_item_t eof_item();
    in_item_t item;
    item            = '0;
    item.func       = FUNC_EOF;
    // Junk in the unused fields must not matter.
    item.red        = 8'($urandom);
    item.green      = 8'($urandom);
    item.blue       = 8'($urandom);
    item.brightness = 8'($urandom);
    return item;
  endfunction

  function automatic in_item_t random_pixel();
    logic [7:0] bright;
    case ($urandom_range(0, 3))
      0:       bright = 8'd0;
      1:       bright = 8'd255;
      default: bright = 8'($urandom);
    endcase
    return pixel(8'($urandom), 8'($urandom), 8'($urandom), bright);
  endfunction

  initial begin : stimulus
    int sent;
    int npix;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    no_stall  = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on reset defaults: extremes, zero brightness, bit patterns,
    // end of frame with and without an open frame.
    send_item(pixel(8'd255, 8'd255, 8'd255, 8'd255));
    send_item(pixel(8'd0, 8'd0, 8'd0, 8'd255));
    send_item(pixel(8'hAA, 8'h55, 8'h0F, 8'd255));
    send_item(pixel(8'd255, 8'd255, 8'd255, 8'd0));
    send_item(pixel(8'd200, 8'd100, 8'd50, 8'd127));
    send_item(eof_item());
    send_item(eof_item());
    send_item(pixel(8'd1, 8'd128, 8'd254, 8'd255));
    drain();

    // No leading run (upper data bits masked off), zero reset gap, duty extremes,
    // writes to unlisted indexes that must be ignored.
    write_reg(CFG_LEADING, 8'hF0);
    write_reg(CFG_RESET_GAP, 8'd0);
    write_reg(CFG_DUTY_ZERO, 8'd0);
    write_reg(CFG_DUTY_ONE, 8'd255);
    write_reg(8'd4, 8'hFF);
    write_reg(8'd255, 8'h5A);
    send_item(pixel(8'd255, 8'd0, 8'd255, 8'd255));
    send_item(eof_item());
    send_item(eof_item());
    drain();

    // Longest leading run and reset gap, duties swapped to the other extreme.
    write_reg(CFG_LEADING, 8'h0F);
    write_reg(CFG_RESET_GAP, 8'd255);
    write_reg(CFG_DUTY_ZERO, 8'd255);
    write_reg(CFG_DUTY_ONE, 8'd0);
    send_item(pixel(8'd0, 8'd255, 8'd0, 8'd255));
    send_item(pixel(8'd128, 8'd128, 8'd128, 8'd1));
    send_item(eof_item());
    drain();

    write_reg(CFG_RESET_GAP, 8'd1);
    write_reg(CFG_LEADING, 8'hFF);
    send_item(random_pixel());
    send_item(eof_item());
    drain();

    // Random part: mostly whole frames, some stray end-of-frame items and some
    // frames left open across the next one.
    for (int phase = 0; phase < 8; phase++) begin
      no_stall = 1'b0;
      case (phase)
        0: begin
          write_reg(CFG_DUTY_ZERO, 8'd0);
          write_reg(CFG_DUTY_ONE, 8'd0);
          write_reg(CFG_RESET_GAP, 8'd0);
          write_reg(CFG_LEADING, 8'd0);
        end
        1: begin
          write_reg(CFG_DUTY_ZERO, 8'd255);
          write_reg(CFG_DUTY_ONE, 8'd255);
          write_reg(CFG_RESET_GAP, 8'd255);
          write_reg(CFG_LEADING, 8'd255);
        end
        default: begin
          write_reg(CFG_DUTY_ZERO, 8'($urandom));
          write_reg(CFG_DUTY_ONE, 8'($urandom));
          write_reg(CFG_RESET_GAP, 8'($urandom));
          write_reg(CFG_LEADING, 8'($urandom));
        end
      endcase
      write_reg(8'($urandom_range(4, 255)), 8'($urandom));

      sent = 0;
      while (sent < 56) begin
        // Some frames run with no idling on either side.
        no_stall = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
          8: begin
            send_item(eof_item());
            sent++;
          end
          9: begin
            npix = $urandom_range(1, 3);
            repeat (npix) send_item(random_pixel());
            sent += npix;
          end
          default: begin
            npix = $urandom_range(1, 5);
            repeat (npix) send_item(random_pixel());
            send_item(eof_item());
            sent += npix + 1;
          end
        endcase
      end
      drain();
    end

    // Leave room for any stray result to show up before the verdict.
    repeat (40) @(negedge clk);
    if (fail_count == 0 && runs_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
